// ===== src/monomer_sequence_ngram_counter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Monomer sequence n-gram counter: assertion macros
// Shared property wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MONOMER_SEQUENCE_NGRAM_COUNTER_UNIT_DEFINES_SVH
`define MONOMER_SEQUENCE_NGRAM_COUNTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSNGC_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSNGC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/msngc_pkg.sv =====
// ----------------------------------------------------------------------------
// msngc_pkg
// Widths, command codes and shared types of the monomer sequence n-gram counter.
// ----------------------------------------------------------------------------
`default_nettype none

package msngc_pkg;

	// Field widths of the input and result beats.
	localparam int CMD_W    = 2;
	localparam int UNIT_W   = 4;
	localparam int POS_W    = 10;
	localparam int PLEN_W   = 3;
	localparam int MATCH_W  = 10;
	localparam int LEN_W    = 11;
	localparam int DYAD_W   = 7;
	localparam int TRIAD_W  = 10;

	// Default store capacity.
	localparam int MAX_UNITS_DEF = 1024;

	// Window cells: one for each unit of the longest pattern.
	localparam int WIN_CELLS = 5;
	localparam int PIDX_W    = $clog2(WIN_CELLS);
	localparam int PLEN_MIN  = 2;

	// Value limits and decimal weights.
	localparam int UNIT_MAX    = 9;
	localparam int DEC_TEN     = 10;
	localparam int DEC_HUNDRED = 100;
	localparam logic [MATCH_W-1:0] MATCH_MAX = MATCH_W'(1023);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	// Data handed from one window cell to the next.
	typedef struct packed {
		logic              valid;
		logic [UNIT_W-1:0] unit;
	} cell_link_t;

endpackage

`default_nettype wire

// ===== src/msngc_ram.sv =====
// ----------------------------------------------------------------------------
// msngc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msngc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/msngc_cell.sv =====
// ----------------------------------------------------------------------------
// msngc_cell
// One window cell: holds one streamed unit and one pattern unit, compares them
// and passes its unit on to the next cell every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msngc_cell
	import msngc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic              pat_used,
	input  wire logic [UNIT_W-1:0] pat_unit,
	input  wire cell_link_t        link_in,
	input  wire logic              hit_in,
	output cell_link_t             link_out,
	output logic                   hit_out
);

	logic              valid_q;
	logic [UNIT_W-1:0] unit_q;
	logic              used_q;
	logic [UNIT_W-1:0] pat_q;

	// Stream register: cleared when a new scan is loaded, otherwise shifts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b0;
			used_q  <= pat_used;
		end else begin
			valid_q <= link_in.valid;
		end
	end

	// Payload of the cell: streamed unit and its pattern unit.
	always_ff @(posedge clk) begin
		if (load) begin
			pat_q <= pat_unit;
		end
		unit_q <= link_in.unit;
	end

	// A cell outside the pattern passes the hit through unchanged.
	assign hit_out  = hit_in & (!used_q | (valid_q & (unit_q == pat_q)));
	assign link_out = '{valid: valid_q, unit: unit_q};

endmodule

`default_nettype wire

// ===== src/monomer_sequence_ngram_counter_unit.sv =====
// ----------------------------------------------------------------------------
// monomer_sequence_ngram_counter_unit
// Stack of monomer types with push, pop, positional read and a windowed
// pattern count done by streaming the store through a row of compare cells.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in      | input     | in_valid / in_ready | command, monomer_type, position,
//          |           |                     | pattern_len, pat0 .. pat4
//  out     | output    | out_valid/out_ready | match_count, chain_length, initiated,
//          |           |                     | last_unit, last_dyad, last_triad,
//          |           |                     | unit_at, error
//
// A push, a rejected command, a pop leaving under three units, a read past the
// end or a count that cannot match goes from acceptance straight to ST_FIN. Any
// other pop or read passes a wait state, set by the registered read port of the
// store. A scanning count does one store read a cycle into the window row, then
// drains the row in ST_DRAIN. Reset clears the length, the sequencer, handshake
// and cell flags. A beat is taken while a result waits; the next one is held.
// ----------------------------------------------------------------------------
`default_nettype none

module monomer_sequence_ngram_counter_unit
	import msngc_pkg::*;
#(
	parameter int MAX_UNITS = MAX_UNITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [UNIT_W-1:0]  monomer_type,
	input  wire logic [POS_W-1:0]   position,
	input  wire logic [PLEN_W-1:0]  pattern_len,
	input  wire logic [UNIT_W-1:0]  pat0,
	input  wire logic [UNIT_W-1:0]  pat1,
	input  wire logic [UNIT_W-1:0]  pat2,
	input  wire logic [UNIT_W-1:0]  pat3,
	input  wire logic [UNIT_W-1:0]  pat4,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [MATCH_W-1:0] match_count,
	output logic      [LEN_W-1:0]   chain_length,
	output logic                    initiated,
	output logic      [UNIT_W-1:0]  last_unit,
	output logic      [DYAD_W-1:0]  last_dyad,
	output logic      [TRIAD_W-1:0] last_triad,
	output logic      [UNIT_W-1:0]  unit_at,
	output logic                    error
);

	localparam int AW   = $clog2(MAX_UNITS);
	localparam int CW   = $clog2(MAX_UNITS + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int PLCW = (CW > PLEN_W) ? CW : PLEN_W;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_POP_WT  = 3'd1;
	localparam logic [2:0] ST_READ_WT = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_DRAIN   = 3'd4;
	localparam logic [2:0] ST_FIN     = 3'd5;

	logic [2:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      scan_q;
	logic               drain_q;
	logic               scan_s1;
	logic [UNIT_W-1:0]  a_q;
	logic [UNIT_W-1:0]  b_q;
	logic [UNIT_W-1:0]  c_q;
	logic [MATCH_W-1:0] match_q;
	logic [UNIT_W-1:0]  unit_at_q;
	logic               err_q;
	logic               out_valid_q;

	logic               in_fire;
	logic               out_load;
	logic               push_ok;
	logic               pop_ok;
	logic               read_hit;
	logic               count_ok;
	logic               wr_en;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [UNIT_W-1:0]  rd_data;

	logic [UNIT_W-1:0]  pat_arr [WIN_CELLS];
	logic [UNIT_W-1:0]  pat_sel [WIN_CELLS];
	logic [WIN_CELLS-1:0] pat_used;
	logic [PLEN_W-1:0]  pidx;
	cell_link_t         link [WIN_CELLS+1];
	logic [WIN_CELLS:0] hit;

	logic [DYAD_W-1:0]  dyad_val;
	logic [TRIAD_W-1:0] triad_val;

	// Handshake and command qualification.
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_load = (state_q == ST_FIN) & (!out_valid_q | out_ready);

	assign push_ok  = (count_q != CW'(MAX_UNITS)) && (monomer_type <= UNIT_W'(UNIT_MAX));
	assign pop_ok   = (count_q != '0);
	assign read_hit = (CMPW'(position) < CMPW'(count_q));
	assign count_ok = (pattern_len >= PLEN_W'(PLEN_MIN)) && (pattern_len <= PLEN_W'(WIN_CELLS))
		&& (PLCW'(count_q) >= PLCW'(pattern_len));

	// Store ports: push writes the top, pop refetches the new third-last unit,
	// read fetches the requested entry and a scan walks the whole chain.
	assign wr_en = in_fire && (command == CMD_PUSH) && push_ok;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == ST_SCAN) begin
			rd_en   = 1'b1;
			rd_addr = AW'(scan_q);
		end else if (in_fire && (command == CMD_POP) && (count_q >= CW'(4))) begin
			rd_en   = 1'b1;
			rd_addr = AW'(count_q - CW'(4));
		end else if (in_fire && (command == CMD_READ) && read_hit) begin
			rd_en   = 1'b1;
			rd_addr = AW'(position);
		end
	end

	msngc_ram #(
		.WIDTH (UNIT_W),
		.DEPTH (MAX_UNITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(count_q)),
		.wr_data (monomer_type),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Pattern order for the cells: cell 0 sees the newest unit of a window,
	// so it compares against the last pattern unit.
	assign pat_arr[0] = pat0;
	assign pat_arr[1] = pat1;
	assign pat_arr[2] = pat2;
	assign pat_arr[3] = pat3;
	assign pat_arr[4] = pat4;

	always_comb begin
		pidx = '0;
		for (int k = 0; k < WIN_CELLS; k++) begin
			pat_used[k] = (PLEN_W'(k) < pattern_len);
			pidx        = pattern_len - PLEN_W'(1) - PLEN_W'(k);
			pat_sel[k]  = '0;
			if (pat_used[k] && (pidx < PLEN_W'(WIN_CELLS))) begin
				pat_sel[k] = pat_arr[PIDX_W'(pidx)];
			end
		end
	end

	// Row of window cells fed by the store read port.
	assign link[0] = '{valid: scan_s1, unit: rd_data};
	assign hit[0]  = 1'b1;

	for (genvar g = 0; g < WIN_CELLS; g++) begin : g_cell
		msngc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (in_fire && (command == CMD_COUNT)),
			.pat_used (pat_used[g]),
			.pat_unit (pat_sel[g]),
			.link_in  (link[g]),
			.hit_in   (hit[g]),
			.link_out (link[g+1]),
			.hit_out  (hit[g+1])
		);
	end

	// Sequencer and stack bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			drain_q <= 1'b0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_FIN;
						case (command)
							CMD_PUSH: begin
								if (push_ok) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_POP: begin
								if (pop_ok) begin
									count_q <= count_q - CW'(1);
									if (count_q >= CW'(4)) begin
										state_q <= ST_POP_WT;
									end
								end
							end
							CMD_COUNT: begin
								if (count_ok) begin
									scan_q  <= '0;
									state_q <= ST_SCAN;
								end
							end
							CMD_READ: begin
								if (read_hit) begin
									state_q <= ST_READ_WT;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_POP_WT: begin
					state_q <= ST_FIN;
				end
				ST_READ_WT: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					scan_q <= scan_q + CW'(1);
					if (scan_q == count_q - CW'(1)) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working result and the last three units of the chain.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			match_q   <= '0;
			unit_at_q <= '0;
			err_q     <= 1'b0;
			case (command)
				CMD_PUSH: begin
					if (push_ok) begin
						a_q <= b_q;
						b_q <= c_q;
						c_q <= monomer_type;
					end else begin
						err_q <= 1'b1;
					end
				end
				CMD_POP: begin
					if (pop_ok) begin
						c_q <= b_q;
						b_q <= a_q;
					end else begin
						err_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_POP_WT) begin
			a_q <= rd_data;
		end
		if (state_q == ST_READ_WT) begin
			unit_at_q <= rd_data;
		end
		// A new unit in cell 0 closes exactly one window.
		if (((state_q == ST_SCAN) || (state_q == ST_DRAIN)) && link[1].valid
			&& hit[WIN_CELLS] && (match_q != MATCH_MAX)) begin
			match_q <= match_q + MATCH_W'(1);
		end
	end

	// Decimal codes of the chain tail.
	assign dyad_val  = DYAD_W'(b_q) * DYAD_W'(DEC_TEN) + DYAD_W'(c_q);
	assign triad_val = TRIAD_W'(a_q) * TRIAD_W'(DEC_HUNDRED)
		+ TRIAD_W'(b_q) * TRIAD_W'(DEC_TEN) + TRIAD_W'(c_q);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			match_count  <= match_q;
			chain_length <= LEN_W'(count_q);
			initiated    <= (count_q != '0);
			last_unit    <= (count_q >= CW'(1)) ? c_q : '0;
			last_dyad    <= (count_q >= CW'(2)) ? dyad_val : '0;
			last_triad   <= (count_q >= CW'(3)) ? triad_val : '0;
			unit_at      <= unit_at_q;
			error        <= err_q;
		end
	end

	assign out_valid = out_valid_q;

	// Checks on the sequencer and stack.
`include "monomer_sequence_ngram_counter_unit_defines.svh"

	`MSNGC_ASSERT_NEXT(a_push_grows, in_fire && (command == CMD_PUSH) && push_ok, count_q == $past(count_q) + CW'(1), "accepted push did not grow the chain")
	`MSNGC_ASSERT_SAME(a_scan_bound, state_q == ST_SCAN, scan_q < count_q, "scan address ran past the chain")
	`MSNGC_ASSERT_SAME(a_err_quiet, out_valid && error, (match_count == '0) && (unit_at == '0), "rejected command carried a count or unit")

endmodule

`default_nettype wire
